@@ hw/rtl/ecw_pkg.sv @@
// Shared constants and controller/datapath interface types for the Euler circuit walker.
package ecw_pkg;

  // Width of a vertex number on the ports.
  localparam int VTX_W = 4;

  // Operation codes of an input item.
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add;        // store one edge from the input item
    logic start;      // set up a walk from vertex 0
    logic probe;      // look at the current vertex's newest unused edge
    logic take;       // follow the edge read in the probe step
    logic restore;    // backtrack to the vertex popped from the path stack
    logic emit_rd;    // read the next circuit vertex for output
    logic emit_done;  // a result transfer completed
    logic clear;      // empty the edge store after the run
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_avail;   // current vertex still has an unused edge
    logic stack_empty;  // path stack has been fully unwound
    logic out_last;     // the vertex on the output is the final one
  } sts_t;

endpackage

@@ hw/rtl/ecw_ctrl.sv @@
// Sequencing state machine for edge loading, the circuit walk and result output.
module ecw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  ecw_pkg::sts_t sts,
  output ecw_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_TAKE,
    S_POP,
    S_EMIT_RD,
    S_EMIT_SHOW
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   xfer;

  // Input is taken only while no run is in progress.
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign xfer      = out_valid_r && !out_stall;

  // Commands follow directly from the state and the handshakes.
  always_comb begin
    cmd           = '0;
    cmd.add       = accept && (in_op == ecw_pkg::OP_ADD);
    cmd.start     = accept && (in_op == ecw_pkg::OP_RUN);
    cmd.probe     = (state_r == S_PROBE);
    cmd.take      = (state_r == S_TAKE);
    cmd.restore   = (state_r == S_POP);
    cmd.emit_rd   = (state_r == S_EMIT_RD);
    cmd.emit_done = xfer;
    cmd.clear     = xfer && sts.out_last;
  end

  // Next state and next output valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = sts.edge_avail ? S_TAKE : S_POP;
      end
      S_TAKE: begin
        state_nxt = S_PROBE;
      end
      S_POP: begin
        state_nxt = sts.stack_empty ? S_EMIT_RD : S_PROBE;
      end
      S_EMIT_RD: begin
        state_nxt     = S_EMIT_SHOW;
        out_valid_nxt = 1'b1;
      end
      S_EMIT_SHOW: begin
        if (xfer) begin
          out_valid_nxt = 1'b0;
          state_nxt     = sts.out_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/ecw_dpath.sv @@
// Edge lists, path stack, circuit store and counters of the Euler circuit walker.
module ecw_dpath #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_EDGES    = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ecw_pkg::cmd_t             cmd,
  output ecw_pkg::sts_t             sts,
  input  logic [ecw_pkg::VTX_W-1:0] in_from_vertex,
  input  logic [ecw_pkg::VTX_W-1:0] in_to_vertex,
  output logic [ecw_pkg::VTX_W-1:0] out_vertex,
  output logic                      out_last,
  output logic                      out_edges_dropped
);

  // Only vertices that the ports can name need a list head.
  localparam int NV      = (MAX_VERTICES < (1 << ecw_pkg::VTX_W)) ?
                           MAX_VERTICES : (1 << ecw_pkg::VTX_W);
  localparam int VIDX_W  = $clog2(NV);
  localparam int LW      = $clog2(MAX_EDGES + 1);
  localparam int EIW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int PDEPTH  = MAX_EDGES + 1;
  localparam int PIW     = $clog2(PDEPTH);
  localparam int SW      = $clog2(PDEPTH + 1);
  localparam int EWORD   = VIDX_W + LW;
  localparam logic [LW-1:0] NIL = LW'(MAX_EDGES);

  // List heads with a valid bit per vertex; an invalid head reads as empty.
  logic [LW-1:0]     head_r [NV];
  logic [NV-1:0]     head_vld_r;
  // Edge store: destination and link to the next older edge of the same list.
  logic [EWORD-1:0]  edge_mem [MAX_EDGES];
  logic [EWORD-1:0]  edge_rd_r;
  // Path stack and completed-vertex store.
  logic [VIDX_W-1:0] ps_mem [PDEPTH];
  logic [VIDX_W-1:0] ps_rd_r;
  logic [VIDX_W-1:0] cs_mem [PDEPTH];
  logic [VIDX_W-1:0] cs_rd_r;

  logic [LW-1:0]     loaded_r;
  logic              ovf_r;
  logic [SW-1:0]     depth_r;
  logic [SW-1:0]     depth_m1;
  logic [SW-1:0]     clen_r;
  logic [PIW-1:0]    out_idx_r;
  logic [VIDX_W-1:0] cur_r;
  logic              last_r;

  logic [VIDX_W-1:0] hidx;
  logic [LW-1:0]     head_e;
  logic              range_ok;
  logic              full;
  logic              add_go;
  logic              record;
  logic [VIDX_W-1:0] rd_target;
  logic [LW-1:0]     rd_link;

  logic              ps_we;
  logic [PIW-1:0]    ps_wa;
  logic [VIDX_W-1:0] ps_wd;

  // Head lookup: the source vertex during an add, the current vertex otherwise.
  assign hidx     = cmd.add ? in_from_vertex[VIDX_W-1:0] : cur_r;
  assign head_e   = head_vld_r[hidx] ? head_r[hidx] : NIL;
  assign range_ok = (32'(in_from_vertex) < MAX_VERTICES) &&
                    (32'(in_to_vertex) < MAX_VERTICES);
  assign full     = (loaded_r == NIL);
  assign add_go   = cmd.add && range_ok && !full;
  assign record   = cmd.probe && (head_e == NIL);
  assign depth_m1 = depth_r - SW'(1);

  assign rd_target = edge_rd_r[EWORD-1:LW];
  assign rd_link   = edge_rd_r[LW-1:0];

  assign sts.edge_avail  = (head_e != NIL);
  assign sts.stack_empty = (depth_r == '0);
  assign sts.out_last    = last_r;

  assign out_vertex        = ecw_pkg::VTX_W'(cs_rd_r);
  assign out_last          = last_r;
  assign out_edges_dropped = ovf_r;

  // Edge store write on add, registered read on probe.
  always_ff @(posedge clk) begin
    if (add_go) begin
      edge_mem[loaded_r[EIW-1:0]] <= {in_to_vertex[VIDX_W-1:0], head_e};
    end
    if (cmd.probe && sts.edge_avail) begin
      edge_rd_r <= edge_mem[head_e[EIW-1:0]];
    end
  end

  // List heads: new edge goes in front on add, the taken edge is unlinked on take.
  always_ff @(posedge clk) begin
    if (add_go) begin
      head_r[hidx] <= loaded_r;
    end else if (cmd.take) begin
      head_r[cur_r] <= rd_link;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
    end else if (cmd.clear) begin
      head_vld_r <= '0;
    end else if (add_go) begin
      head_vld_r[hidx] <= 1'b1;
    end
  end

  // Edge count and sticky overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (cmd.clear) begin
        loaded_r <= '0;
      end else if (add_go) begin
        loaded_r <= loaded_r + LW'(1);
      end
      if (cmd.add && range_ok && full) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Path stack: vertex 0 is pushed at start, the current vertex on each take.
  always_comb begin
    ps_we = cmd.start || cmd.take;
    ps_wa = cmd.start ? '0 : depth_r[PIW-1:0];
    ps_wd = cmd.start ? '0 : cur_r;
  end

  always_ff @(posedge clk) begin
    if (ps_we) begin
      ps_mem[ps_wa] <= ps_wd;
    end
    if (record) begin
      ps_rd_r <= ps_mem[depth_m1[PIW-1:0]];
    end
  end

  // Completed vertices are stored in order and read back from the newest.
  always_ff @(posedge clk) begin
    if (record) begin
      cs_mem[clen_r[PIW-1:0]] <= cur_r;
    end
    if (cmd.emit_rd) begin
      cs_rd_r <= cs_mem[out_idx_r];
      last_r  <= (out_idx_r == '0);
    end
  end

  // Walk registers: stack depth, circuit length, output index, current vertex.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      clen_r  <= '0;
    end else if (cmd.start) begin
      depth_r <= SW'(1);
      clen_r  <= '0;
    end else if (cmd.take) begin
      depth_r <= depth_r + SW'(1);
    end else if (record) begin
      depth_r <= depth_m1;
      clen_r  <= clen_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_r <= '0;
    end else if (cmd.take) begin
      cur_r <= rd_target;
    end else if (cmd.restore) begin
      cur_r <= ps_rd_r;
    end
    if (record) begin
      out_idx_r <= clen_r[PIW-1:0];
    end else if (cmd.emit_done) begin
      out_idx_r <= out_idx_r - PIW'(1);
    end
  end

endmodule

@@ hw/rtl/euler_circuit_walker_core.sv @@
// Euler circuit walker: loads directed edges, then walks and streams the circuit from vertex 0.
// An add item (op 0) is taken while no run is in progress and returns nothing; an edge beyond MAX_EDGES is
// dropped and sets edges_dropped, which stays set until reset. A run item (op 1) walks from
// vertex 0, always following the newest unused edge of the current vertex. Each forward step
// passes through the probe and take states and each backtrack through the probe and pop states,
// because the edge memory and the path stack both have a registered read. For E reachable
// edges the E + 1 circuit vertices then leave one by one: each is first read from the circuit
// store and then presented, and the next is read only after it transfers, last marking the
// final vertex. No input is taken from the run transfer until the last result transfers. After
// each run the edge store is empty again; list heads carry valid bits, so neither reset nor a
// run needs a clearing pass.
module euler_circuit_walker_core #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_EDGES    = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_op,
  input  logic [ecw_pkg::VTX_W-1:0] in_from_vertex,
  input  logic [ecw_pkg::VTX_W-1:0] in_to_vertex,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ecw_pkg::VTX_W-1:0] out_vertex,
  output logic                      out_last,
  output logic                      out_edges_dropped
);

  ecw_pkg::cmd_t cmd;
  ecw_pkg::sts_t sts;

  // Sequencer.
  ecw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and counters.
  ecw_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_from_vertex    (in_from_vertex),
    .in_to_vertex      (in_to_vertex),
    .out_vertex        (out_vertex),
    .out_last          (out_last),
    .out_edges_dropped (out_edges_dropped)
  );

endmodule

@@ hw/rtl/ecw_checker.sv @@
// Port-level checks for the Euler circuit walker and their bind to the top level.
module ecw_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      in_op,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [ecw_pkg::VTX_W-1:0] out_vertex,
  input logic                      out_last,
  input logic                      out_edges_dropped
);

  logic seen_drop_r;

  // Remember whether any result has reported a dropped edge since reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_drop_r <= 1'b0;
    end else if (out_valid && out_edges_dropped) begin
      seen_drop_r <= 1'b1;
    end
  end

  // No input is taken while results are being delivered.
  a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // A stalled result holds its payload.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex) && $stable(out_last))
    else $error("stalled result changed");

  // The run transfer closes the input until the circuit has been sent.
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == ecw_pkg::OP_RUN) |=> in_stall)
    else $error("input open right after a run transfer");

  // The final result ends the run's output.
  a_last_ends_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid)
    else $error("result shown after the final vertex");

  // The dropped-edge flag never clears once reported.
  a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_drop_r |-> out_edges_dropped)
    else $error("dropped-edge flag cleared");

endmodule

bind euler_circuit_walker_core ecw_checker u_ecw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_op             (in_op),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_vertex        (out_vertex),
  .out_last          (out_last),
  .out_edges_dropped (out_edges_dropped)
);
